FILE: src/pate_pkg.sv
// Shared types, constants and helper functions of the truecolor terminal encoder.
// No dependencies; every other file of the block imports this package.
package pate_pkg;

  // frame geometry
  localparam int MAX_SIDE = 1024;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CNT_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  // configuration port
  localparam int CFG_W   = 11;
  localparam int INDEX_W = 2;
  localparam logic [INDEX_W-1:0] REG_FRAME_WIDTH  = INDEX_W'(0);
  localparam logic [INDEX_W-1:0] REG_FRAME_HEIGHT = INDEX_W'(1);
  localparam logic [CFG_W-1:0]   WIDTH_RESET      = CFG_W'(80);
  localparam logic [CFG_W-1:0]   HEIGHT_RESET     = CFG_W'(24);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // byte slots of the output sequence for one pixel
  localparam int SLOT_W = 6;
  localparam logic [SLOT_W-1:0] SLOT_ESC_FG  = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_R       = SLOT_W'(7);
  localparam logic [SLOT_W-1:0] SLOT_G       = SLOT_W'(11);
  localparam logic [SLOT_W-1:0] SLOT_B       = SLOT_W'(15);
  localparam logic [SLOT_W-1:0] SLOT_BLOCK   = SLOT_W'(19);
  localparam logic [SLOT_W-1:0] SLOT_NEWLINE = SLOT_W'(22);
  localparam logic [SLOT_W-1:0] SLOT_RESET   = SLOT_W'(30);
  localparam logic [SLOT_W-1:0] SLOT_LAST    = SLOT_W'(33);
  localparam logic [SLOT_W-1:0] SLOT_DONE    = SLOT_W'(63);

  localparam logic [7:0] CHAR_ESC     = 8'h1B;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_BLOCK_0 = 8'hE2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_pixel;
    logic       frame_done;
  } text_t;

  // one classified pixel, as the back end needs it
  typedef struct packed {
    logic        colour_esc;
    logic        row_end;
    logic        frame_end;
    logic [11:0] red_bcd;
    logic [11:0] green_bcd;
    logic [11:0] blue_bcd;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // 8-bit binary to three bcd digits, shift and add-three
  function automatic logic [11:0] to_bcd(input logic [7:0] v);
    logic [19:0] s;
    s = {12'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (s[11:8] >= 4'd5)  s[11:8]  = s[11:8] + 4'd3;
      if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
      if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
      s = s << 1;
    end
    return s[19:8];
  endfunction

  // fixed bytes of the sequence; digit slots are filled in by the back end
  function automatic logic [7:0] slot_byte(input logic [SLOT_W-1:0] slot);
    logic [7:0] b;
    case (slot)
      SLOT_ESC_FG:                  b = CHAR_ESC;
      SLOT_ESC_FG + SLOT_W'(1):     b = 8'h5B;  // [
      SLOT_ESC_FG + SLOT_W'(2):     b = 8'h33;  // 3
      SLOT_ESC_FG + SLOT_W'(3):     b = 8'h38;  // 8
      SLOT_ESC_FG + SLOT_W'(4):     b = 8'h3B;  // ;
      SLOT_ESC_FG + SLOT_W'(5):     b = 8'h32;  // 2
      SLOT_ESC_FG + SLOT_W'(6):     b = 8'h3B;
      SLOT_G - SLOT_W'(1), SLOT_B - SLOT_W'(1): b = 8'h3B;
      SLOT_BLOCK - SLOT_W'(1):      b = 8'h6D;  // m
      SLOT_BLOCK:                   b = CHAR_BLOCK_0;
      SLOT_BLOCK + SLOT_W'(1):      b = 8'h96;
      SLOT_BLOCK + SLOT_W'(2):      b = 8'h88;
      SLOT_NEWLINE, SLOT_NEWLINE + SLOT_W'(4), SLOT_RESET: b = CHAR_ESC;
      SLOT_NEWLINE + SLOT_W'(1), SLOT_NEWLINE + SLOT_W'(5), SLOT_RESET + SLOT_W'(1):
                                    b = 8'h5B;
      SLOT_NEWLINE + SLOT_W'(2):    b = 8'h31;  // 1
      SLOT_NEWLINE + SLOT_W'(3):    b = 8'h45;  // E
      SLOT_NEWLINE + SLOT_W'(6), SLOT_RESET + SLOT_W'(2): b = CHAR_ZERO;
      SLOT_NEWLINE + SLOT_W'(7):    b = 8'h47;  // G
      SLOT_LAST:                    b = 8'h6D;
      default:                      b = CHAR_ZERO;
    endcase
    return b;
  endfunction

endpackage

FILE: src/pixel_to_ansi_truecolor_encoder.sv
// channel   | direction | signals                               | transfer when
// config    | in        | cfg_write, cfg_index, cfg_data        | cfg_write high
// pixel     | in        | pixel_valid, pixel_stall, pixel       | valid high, stall low
// text      | out       | text_valid, text_stall, text          | valid high, stall low
//
// One text byte leaves per cycle while a pixel is queued and the output is not stalled;
// a pixel gives 3 to 34 bytes, set by the byte sequencer of the back end that walks one
// slot per byte. Pixels are taken while the four-entry command queue has room, also
// while the output byte is stalled. With the queue empty, the first byte of a pixel
// passes through the queue entry and then the registered text output.
// Synchronous reset clears position, colour state, queue and output; sizes go to 80 by 24.
// Top level of the truecolor terminal encoder; depends on pate_pkg, pate_front,
// pate_queue and pate_back.
module pixel_to_ansi_truecolor_encoder
  import pate_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  pixel_t             pixel,
  output logic               text_valid,
  input  logic               text_stall,
  output text_t              text
);

  queue_status_t qstat;
  logic          push;
  logic          pop;
  cmd_t          push_cmd;
  cmd_t          head;

  // classification
  pate_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .qstat       (qstat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // decoupling queue
  pate_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  // byte generation
  pate_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .text_valid (text_valid),
    .text_stall (text_stall),
    .text       (text)
  );

endmodule

FILE: src/pate_front.sv
// Front end: size registers, raster position, colour tracking and pixel classification.
// Depends on pate_pkg; pushes one cmd_t per accepted pixel into the queue.
module pate_front
  import pate_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  pixel_t             pixel,
  input  queue_status_t      qstat,
  output logic               push,
  output cmd_t               push_cmd
);

  localparam int CMP_W = SIDE_W + 1;

  logic [CFG_W-1:0]  frame_width;
  logic [CFG_W-1:0]  frame_height;
  logic [23:0]       current_colour;
  logic              colour_valid;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;

  logic [SIDE_W-1:0] w_eff;
  logic [SIDE_W-1:0] h_eff;
  logic [23:0]       colour;
  logic              colour_esc;
  logic              row_end;
  logic              frame_end;

  function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] r);
    logic [SIDE_W-1:0] s;
    if (r == '0) s = SIDE_W'(1);
    else if (32'(r) > MAX_SIDE) s = SIDE_W'(MAX_SIDE);
    else s = SIDE_W'(r);
    return s;
  endfunction

  // classification of the incoming pixel
  always_comb begin
    w_eff      = eff_side(frame_width);
    h_eff      = eff_side(frame_height);
    colour     = {pixel.red, pixel.green, pixel.blue};
    colour_esc = !colour_valid || (colour != current_colour);
    row_end    = (CMP_W'(column_count) + CMP_W'(1)) >= CMP_W'(w_eff);
    frame_end  = row_end && ((CMP_W'(row_count) + CMP_W'(1)) >= CMP_W'(h_eff));
  end

  assign pixel_stall = qstat.full;
  assign push        = pixel_valid && !qstat.full;

  always_comb begin
    push_cmd.colour_esc = colour_esc;
    push_cmd.row_end    = row_end;
    push_cmd.frame_end  = frame_end;
    push_cmd.red_bcd    = to_bcd(pixel.red);
    push_cmd.green_bcd  = to_bcd(pixel.green);
    push_cmd.blue_bcd   = to_bcd(pixel.blue);
  end

  // size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_FRAME_WIDTH) frame_width <= cfg_data;
      else if (cfg_index == REG_FRAME_HEIGHT) frame_height <= cfg_data;
    end
  end

  // position and colour state, updated on each pixel transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      current_colour <= '0;
      colour_valid   <= 1'b0;
      column_count   <= '0;
      row_count      <= '0;
    end else if (push) begin
      current_colour <= colour;
      colour_valid   <= !frame_end;
      if (row_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

endmodule

FILE: src/pate_queue.sv
// Short command queue between the front and back ends.
// Depends on pate_pkg for cmd_t and the queue depth.
module pate_queue
  import pate_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t qstat
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head        = entries[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      if (push && !pop) count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

FILE: src/pate_back.sv
// Back end: byte sequencer that walks the slots of the queue head, one byte per cycle
// unless stalled. Depends on pate_pkg; drives the registered text output.
module pate_back
  import pate_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t qstat,
  output logic          pop,
  output logic          text_valid,
  input  logic          text_stall,
  output text_t         text
);

  logic              started;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] nxt;
  logic              advance;
  logic              emit;
  logic [7:0]        byte_val;

  // first slot of a digit group: hundreds, tens or ones
  function automatic logic [SLOT_W-1:0] lead_digit(input logic [SLOT_W-1:0] base,
                                                   input logic [11:0] bcd);
    logic [SLOT_W-1:0] s;
    if (bcd[11:8] != 4'd0) s = base;
    else if (bcd[7:4] != 4'd0) s = base + SLOT_W'(1);
    else s = base + SLOT_W'(2);
    return s;
  endfunction

  // current and following slot
  always_comb begin
    if (started) cur = slot;
    else cur = head.colour_esc ? SLOT_ESC_FG : SLOT_BLOCK;
    case (cur)
      SLOT_R - SLOT_W'(1):      nxt = lead_digit(SLOT_R, head.red_bcd);
      SLOT_G - SLOT_W'(1):      nxt = lead_digit(SLOT_G, head.green_bcd);
      SLOT_B - SLOT_W'(1):      nxt = lead_digit(SLOT_B, head.blue_bcd);
      SLOT_BLOCK + SLOT_W'(2):  nxt = head.row_end ? SLOT_NEWLINE : SLOT_DONE;
      SLOT_RESET - SLOT_W'(1):  nxt = head.frame_end ? SLOT_RESET : SLOT_DONE;
      SLOT_LAST:                nxt = SLOT_DONE;
      default:                  nxt = cur + SLOT_W'(1);
    endcase
  end

  // byte for the current slot, digits taken from the bcd fields
  always_comb begin
    case (cur)
      SLOT_R:              byte_val = CHAR_ZERO | {4'd0, head.red_bcd[11:8]};
      SLOT_R + SLOT_W'(1): byte_val = CHAR_ZERO | {4'd0, head.red_bcd[7:4]};
      SLOT_R + SLOT_W'(2): byte_val = CHAR_ZERO | {4'd0, head.red_bcd[3:0]};
      SLOT_G:              byte_val = CHAR_ZERO | {4'd0, head.green_bcd[11:8]};
      SLOT_G + SLOT_W'(1): byte_val = CHAR_ZERO | {4'd0, head.green_bcd[7:4]};
      SLOT_G + SLOT_W'(2): byte_val = CHAR_ZERO | {4'd0, head.green_bcd[3:0]};
      SLOT_B:              byte_val = CHAR_ZERO | {4'd0, head.blue_bcd[11:8]};
      SLOT_B + SLOT_W'(1): byte_val = CHAR_ZERO | {4'd0, head.blue_bcd[7:4]};
      SLOT_B + SLOT_W'(2): byte_val = CHAR_ZERO | {4'd0, head.blue_bcd[3:0]};
      default:             byte_val = slot_byte(cur);
    endcase
  end

  assign advance = !text_valid || !text_stall;
  assign emit    = advance && !qstat.empty;
  assign pop     = emit && (nxt == SLOT_DONE);

  // sequencer position
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      slot    <= SLOT_ESC_FG;
    end else if (emit) begin
      started <= (nxt != SLOT_DONE);
      slot    <= nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else if (advance) begin
      text_valid <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      text.out_byte      <= byte_val;
      text.last_of_pixel <= (nxt == SLOT_DONE);
      text.frame_done    <= (nxt == SLOT_DONE) && head.frame_end;
    end
  end

endmodule

FILE: src/pate_checker.sv
// Port-level checks of the truecolor terminal encoder, bound to its top level.
// Depends on pate_pkg.
module pate_checker
  import pate_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   pixel_stall,
  input logic   text_valid,
  input logic   text_stall,
  input text_t  text
);

  logic pixel_start;
  logic frame_start;

  // track where in the stream the next byte falls
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_start <= 1'b1;
      frame_start <= 1'b1;
    end else if (text_valid && !text_stall) begin
      pixel_start <= text.last_of_pixel;
      frame_start <= text.frame_done;
    end
  end

  // a stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_stall |=> text_valid && $stable(text))
    else $error("stalled text byte changed");

  // frame end is always the last byte of a pixel
  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text.frame_done |-> text.last_of_pixel)
    else $error("frame_done without last_of_pixel");

  // a pixel opens with an escape or the block character
  a_pixel_open: assert property (@(posedge clk) disable iff (rst)
    text_valid && pixel_start |-> text.out_byte == CHAR_ESC || text.out_byte == CHAR_BLOCK_0)
    else $error("pixel does not open with escape or block");

  // a frame always opens with a colour escape
  a_frame_open: assert property (@(posedge clk) disable iff (rst)
    text_valid && frame_start |-> text.out_byte == CHAR_ESC)
    else $error("frame does not open with colour escape");

  // reset leaves the queue empty and the output idle
  a_reset: assert property (@(posedge clk)
    rst |=> !pixel_stall && !text_valid)
    else $error("state not cleared by reset");

endmodule

bind pixel_to_ansi_truecolor_encoder pate_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .pixel_stall (pixel_stall),
  .text_valid  (text_valid),
  .text_stall  (text_stall),
  .text        (text)
);

FILE: sim/ansi_text_checker.sv
// Checker for the truecolor terminal encoder: watches the config, pixel and text channels,
// predicts the byte stream of every pixel transfer and compares it byte by byte.
// Depends on pate_pkg for the payload types, register indexes and character constants.
`timescale 1ns / 100ps

module ansi_text_checker
  import pate_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               pixel_valid,
  input  logic               pixel_stall,
  input  pixel_t             pixel,
  input  logic               text_valid,
  input  logic               text_stall,
  input  text_t              text,
  output int                 byte_errors,
  output int                 bytes_pending
);

  // predicted encoder state
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [23:0]      held_colour;
  logic             colour_held;
  logic [CNT_W-1:0] col_pos;
  logic [CNT_W-1:0] row_pos;

  // bytes predicted but not yet seen on the text channel
  text_t pending_text[$];

  initial begin
    byte_errors   = 0;
    bytes_pending = 0;
  end

  // size register as the block uses it: zero acts as one, clipped to the maximum
  function automatic int side_in_force(input logic [CFG_W-1:0] r);
    if (r == '0) return 1;
    if (int'(r) > MAX_SIDE) return MAX_SIDE;
    return int'(r);
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic last, input logic done);
    text_t t;
    t.out_byte      = b;
    t.last_of_pixel = last;
    t.frame_done    = done;
    pending_text.push_back(t);
  endfunction

  function automatic void push_ascii(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i], 1'b0, 1'b0);
    end
  endfunction

  // plain decimal, no leading zeros
  function automatic void push_decimal(input logic [7:0] v);
    if (v >= 8'd100) push_byte(CHAR_ZERO + v / 8'd100, 1'b0, 1'b0);
    if (v >= 8'd10)  push_byte(CHAR_ZERO + (v / 8'd10) % 8'd10, 1'b0, 1'b0);
    push_byte(CHAR_ZERO + v % 8'd10, 1'b0, 1'b0);
  endfunction

  // all bytes caused by one pixel, with the position and colour update
  function automatic void encode_pixel(input pixel_t p);
    logic [23:0] colour;
    int          w;
    int          h;
    logic        row_end;
    logic        frame_end;
    colour    = {p.red, p.green, p.blue};
    w         = side_in_force(width_reg);
    h         = side_in_force(height_reg);
    row_end   = (int'(col_pos) + 1 >= w);
    frame_end = row_end && (int'(row_pos) + 1 >= h);

    // foreground escape on a new colour or the first pixel of a frame
    if (!colour_held || colour != held_colour) begin
      held_colour = colour;
      colour_held = 1'b1;
      push_byte(CHAR_ESC, 1'b0, 1'b0);
      push_ascii("[38;2;");
      push_decimal(p.red);
      push_byte(";", 1'b0, 1'b0);
      push_decimal(p.green);
      push_byte(";", 1'b0, 1'b0);
      push_decimal(p.blue);
      push_byte("m", 1'b0, 1'b0);
    end

    // full block glyph
    push_byte(CHAR_BLOCK_0, 1'b0, 1'b0);
    push_byte(8'h96, 1'b0, 1'b0);
    push_byte(8'h88, !row_end, 1'b0);

    if (row_end) begin
      push_byte(CHAR_ESC, 1'b0, 1'b0);
      push_ascii("[1E");
      push_byte(CHAR_ESC, 1'b0, 1'b0);
      push_ascii("[0");
      push_byte("G", !frame_end, 1'b0);
      col_pos = '0;
      if (frame_end) begin
        push_byte(CHAR_ESC, 1'b0, 1'b0);
        push_ascii("[0");
        push_byte("m", 1'b1, 1'b1);
        row_pos     = '0;
        colour_held = 1'b0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void check_text(input text_t got);
    text_t want;
    if (pending_text.size() == 0) begin
      $error("unexpected text byte %h", got.out_byte);
      byte_errors++;
    end else begin
      want = pending_text.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
        byte_errors++;
      end
      if (got.last_of_pixel !== want.last_of_pixel) begin
        $error("last_of_pixel: expected %b, got %b", want.last_of_pixel, got.last_of_pixel);
        byte_errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %b, got %b", want.frame_done, got.frame_done);
        byte_errors++;
      end
    end
  endfunction

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      width_reg   = WIDTH_RESET;
      height_reg  = HEIGHT_RESET;
      held_colour = '0;
      colour_held = 1'b0;
      col_pos     = '0;
      row_pos     = '0;
      pending_text.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data;
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (pixel_valid && !pixel_stall) encode_pixel(pixel);
      if (text_valid && !text_stall) check_text(text);
    end
    bytes_pending = pending_text.size();
  end

endmodule

FILE: sim/testbench.sv
// Top of the truecolor encoder testbench: clock, reset, pixel stimulus, config writes,
// text back-pressure, watchdog and verdict. Depends on pate_pkg, the encoder and ansi_text_checker.
`timescale 1ns / 100ps

module testbench;
  import pate_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 80;
  localparam int MODE_QUOTA     = 145;

  // indexes past the register list, writes there are dropped
  localparam logic [INDEX_W-1:0] REG_UNUSED_LO = INDEX_W'(2);
  localparam logic [INDEX_W-1:0] REG_UNUSED_HI = INDEX_W'(3);

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_write   = 1'b0;
  logic [INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]   cfg_data    = '0;
  logic               pixel_valid = 1'b0;
  logic               pixel_stall;
  pixel_t             pixel       = '0;
  logic               text_valid;
  logic               text_stall  = 1'b0;
  text_t              text;

  int byte_errors;
  int bytes_pending;

  int sender_gap_pct     = 38;
  int receiver_stall_pct = 63;
  int hold_req           = 0;
  int hold_ack           = 0;
  int hold_left          = 0;
  int quiet_cycles       = 0;

  pixel_t      last_pixel = '0;
  logic [7:0]  digit_edges [6] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255};

  pixel_to_ansi_truecolor_encoder dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text        (text)
  );

  ansi_text_checker text_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel),
    .text_valid    (text_valid),
    .text_stall    (text_stall),
    .text          (text),
    .byte_errors   (byte_errors),
    .bytes_pending (bytes_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // text receiver: random stalls, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack   <= hold_req;
      hold_left  <= HOLD_CYCLES;
      text_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      text_stall <= 1'b1;
    end else begin
      text_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (text_valid && !text_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pixel_to_ansi_truecolor_encoder test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic pixel_t mk_pixel(input int r, input int g, input int b);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    return p;
  endfunction

  // often runs of one colour, some digit-count edges, rest random
  function automatic pixel_t pick_pixel(input pixel_t prev);
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return prev;
    if (roll < 60) begin
      return mk_pixel(digit_edges[$urandom_range(5)], digit_edges[$urandom_range(5)],
                      digit_edges[$urandom_range(5)]);
    end
    return mk_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
  endfunction

  // small frames most of the time, now and then zero or oversize values
  function automatic logic [CFG_W-1:0] pick_side();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return CFG_W'($urandom_range(1, 6));
    if (roll < 90) return '0;
    if (roll < 95) return CFG_W'($urandom_range(7, 2047));
    return CFG_W'(MAX_SIDE);
  endfunction

  // called at a rising edge, returns at the edge of the transfer
  task automatic send_pixel(input pixel_t p);
    while ($urandom_range(99) < sender_gap_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(negedge clk);
    while (pixel_stall) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending and wait until every predicted byte has come out
  task automatic settle();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (bytes_pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic run_directed();
    // first pixel, repeated colour, digit counts one to three
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(9, 10, 99));
    send_pixel(mk_pixel(100, 0, 255));

    // shrink the frame in mid row, then finish that row and the frame
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(3));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    repeat (4) send_pixel(mk_pixel(1, 2, 3));

    // writes past the register list must not touch the sizes
    settle();
    write_reg(REG_UNUSED_LO, CFG_W'(1));
    write_reg(REG_UNUSED_HI, CFG_W'(1));
    send_pixel(mk_pixel(50, 50, 50));

    // zero sizes act as one pixel frames
    settle();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, '0);
    repeat (2) send_pixel(mk_pixel(50, 50, 50));

    // oversize values clip to the maximum
    settle();
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, CFG_W'(MAX_SIDE + 1));
    send_pixel(mk_pixel(255, 0, 255));
    send_pixel(mk_pixel(0, 255, 0));
    send_pixel(mk_pixel(128, 64, 32));
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(MAX_SIDE));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(MAX_SIDE));
    send_pixel(mk_pixel(128, 64, 32));

    // one column: every pixel ends a row
    settle();
    write_reg(REG_FRAME_WIDTH, CFG_W'(1));
    write_reg(REG_FRAME_HEIGHT, CFG_W'(3));
    repeat (3) send_pixel(mk_pixel(7, 7, 7));
    last_pixel = mk_pixel(7, 7, 7);
  endtask

  // batches of pixels with size changes between them while idle
  task automatic run_random(input int quota, input bit with_hold);
    int sent;
    int batch;
    sent = 0;
    while (sent < quota) begin
      settle();
      if ($urandom_range(3) == 0) write_reg(REG_FRAME_WIDTH, pick_side());
      if ($urandom_range(3) == 0) write_reg(REG_FRAME_HEIGHT, pick_side());
      if ($urandom_range(15) == 0) begin
        write_reg($urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI, CFG_W'($urandom()));
      end
      batch = $urandom_range(4, 30);
      if (with_hold && sent == 0) begin
        // receiver holds off while pixels keep coming
        @(negedge clk);
        hold_req++;
        @(posedge clk);
        batch = 40;
      end
      repeat (batch) begin
        last_pixel = pick_pixel(last_pixel);
        send_pixel(last_pixel);
      end
      sent += batch;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    run_random(MODE_QUOTA, 1'b0);
    sender_gap_pct     = 63;
    receiver_stall_pct = 38;
    run_random(MODE_QUOTA, 1'b1);
    sender_gap_pct     = 0;
    receiver_stall_pct = 0;
    run_random(MODE_QUOTA, 1'b1);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (byte_errors == 0 && bytes_pending == 0) begin
      $display("pixel_to_ansi_truecolor_encoder test passed");
    end else begin
      $display("pixel_to_ansi_truecolor_encoder test failed");
    end
    $finish;
  end

endmodule
